// File: rtl/prefix_to_as_number_matcher_defines.svh
// Assertion macros used by the prefix matcher top level
`ifndef PREFIX_TO_AS_NUMBER_MATCHER_DEFINES_SVH
`define PREFIX_TO_AS_NUMBER_MATCHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PTAM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptam assertion failed");

// next-cycle implication, checked out of reset
`define PTAM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptam assertion failed");

`endif

// File: rtl/ptam_pkg.sv
// Types, constants and helpers of the prefix matcher
package ptam_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int AS_PER_PREFIX = 4;
    localparam int ACL_SLOTS     = 4;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(AS_PER_PREFIX + 1);
    localparam int AS_IDX_W      = (AS_PER_PREFIX > 1) ? $clog2(AS_PER_PREFIX) : 1;
    localparam int LEN_W         = 6;
    localparam int ACL_CNT_W     = 3;
    localparam int REG_W         = 3;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

    typedef logic [2:0] t_status;
    localparam t_status ST_NEW       = 3'd0;
    localparam t_status ST_APPENDED  = 3'd1;
    localparam t_status ST_DUPLICATE = 3'd2;
    localparam t_status ST_TBL_FULL  = 3'd3;
    localparam t_status ST_LIST_FULL = 3'd4;
    localparam t_status ST_LOOKUP    = 3'd5;
    localparam t_status ST_REJECT    = 3'd6;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_MATCH = 1'b1;

    typedef logic [REG_W-1:0] t_reg;
    localparam t_reg REG_ACL_COUNT = 3'd0;
    localparam t_reg REG_ACL_AS_0  = 3'd1;

    // token that walks the cell row
    typedef struct packed {
        logic              vld;
        logic              req;
        logic [31:0]       addr;
        logic [LEN_W-1:0]  len;
        logic [31:0]       asn;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic              done;
        t_status           status;
        logic              found;
        logic [LEN_W-1:0]  best_len;
        logic              hit;
    } t_tok;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       pfx;
        logic [LEN_W-1:0]  len;
        logic [31:0]       asn;
    } t_wr;

    typedef struct packed {
        logic [ACL_CNT_W-1:0]             used;
        logic [ACL_SLOTS-1:0][31:0]       as_num;
    } t_acl;

    // len in 0..32
    function automatic logic [31:0] len_mask(input logic [LEN_W-1:0] len);
        len_mask = ~(32'hffff_ffff >> len);
    endfunction
endpackage

// File: rtl/ptam_if.sv
// Item channels of the prefix matcher
interface ptam_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [31:0]                   address;
    logic [5:0]                    prefix_len;
    logic [31:0]                   origin_as;
    modport source (output valid, req_type, address, prefix_len, origin_as, input ready);
    modport sink   (input valid, req_type, address, prefix_len, origin_as, output ready);
endinterface

interface ptam_rsp_if;
    logic       valid;
    logic       ready;
    logic       matched;
    logic [2:0] status;
    modport source (output valid, matched, status, input ready);
    modport sink   (input valid, matched, status, output ready);
endinterface

// File: rtl/ptam_cell.sv
// One table slot: holds a prefix and its AS list, updates the passing token
module ptam_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [ptam_pkg::IDX_W-1:0] i_idx,
    input  ptam_pkg::t_tok           i_tok,
    input  ptam_pkg::t_wr            i_wr,
    input  ptam_pkg::t_acl           i_acl,
    output ptam_pkg::t_tok           o_tok
);
    import ptam_pkg::*;

    logic                              r_valid;
    logic [31:0]                       r_pfx;
    logic [LEN_W-1:0]                  r_len;
    logic [CNT_W-1:0]                  r_cnt;
    logic [AS_PER_PREFIX-1:0][31:0]    r_as;
    t_tok                              r_tok;
    t_tok                              n_tok;
    logic                              w_has;
    logic                              w_hit;
    logic                              w_cover;
    logic                              w_app;
    logic                              w_new;

    always_comb begin
        w_has = 1'b0;
        w_hit = 1'b0;
        for (int k = 0; k < AS_PER_PREFIX; k++) begin
            if (CNT_W'(k) < r_cnt) begin
                if (r_as[k] == i_tok.asn) w_has = 1'b1;
                for (int j = 0; j < ACL_SLOTS; j++) begin
                    if (ACL_CNT_W'(j) < i_acl.used && r_as[k] == i_acl.as_num[j]) w_hit = 1'b1;
                end
            end
        end
        w_cover = (i_tok.addr & len_mask(r_len)) == r_pfx;
    end

    always_comb begin
        n_tok = i_tok;
        w_app = 1'b0;
        if (i_tok.vld) begin
            if (i_tok.req == REQ_ADD) begin
                if (!i_tok.done) begin
                    if (!r_valid) begin
                        if (!i_tok.free_found) begin
                            n_tok.free_found = 1'b1;
                            n_tok.free_idx   = i_idx;
                        end
                    end else if (r_pfx == i_tok.addr && r_len == i_tok.len) begin
                        n_tok.done = 1'b1;
                        if (w_has) begin
                            n_tok.status = ST_DUPLICATE;
                        end else if (r_cnt >= CNT_W'(AS_PER_PREFIX)) begin
                            n_tok.status = ST_LIST_FULL;
                        end else begin
                            n_tok.status = ST_APPENDED;
                            w_app        = 1'b1;
                        end
                    end
                end
            end else if (r_valid && w_cover && (!i_tok.found || r_len > i_tok.best_len)) begin
                n_tok.found    = 1'b1;
                n_tok.best_len = r_len;
                n_tok.hit      = w_hit;
            end
        end
    end

    assign w_new = i_wr.en && (i_wr.idx == i_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (w_new) r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_new) begin
            r_pfx    <= i_wr.pfx;
            r_len    <= i_wr.len;
            r_cnt    <= CNT_W'(1);
            r_as[0]  <= i_wr.asn;
        end else if (w_app) begin
            r_as[r_cnt[AS_IDX_W-1:0]] <= i_tok.asn;
            r_cnt                     <= r_cnt + CNT_W'(1);
        end
    end

    assign o_tok = r_tok;
endmodule

// File: rtl/prefix_to_as_number_matcher.sv
// Top level: config registers, item intake, cell row and result staging
//
// Usage:
//   i_req carries add items (req_type 0: address, prefix_len, origin_as) and
//   match items (req_type 1: address). Each accepted item yields one item on
//   o_rsp with matched and status.
//   The item is registered, then walks a row of 64 slot cells, one cell per
//   cycle; the walk through the row sets the time. A new prefix is written
//   into the first free cell when the token leaves the row.
//   One item is in flight at a time: i_req.ready stays low from accept
//   until the result is staged.
//   When the receiver stalls, the result holds in a pending register and
//   then the output register; i_req.ready returns once the result moves into
//   the output register, so the next item walks while the last one waits.
//   The APB port holds acl_count at 0x0 and acl_as_0..3 at 0x4..0x10;
//   write it only while the block is idle.
//   Reset (synchronous, active low) empties the table and clears the access
//   list; no clearing pass is needed.
`include "prefix_to_as_number_matcher_defines.svh"

module prefix_to_as_number_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptam_req_if.sink    i_req,
    ptam_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ptam_pkg::*;

    logic [ACL_CNT_W-1:0]        r_acl_cnt;
    logic [ACL_SLOTS-1:0][31:0]  r_acl_as;
    t_acl                        w_acl;
    t_reg                        w_reg;
    logic                        w_cfg_wr;

    t_tok                        r_head;
    t_tok                        n_head;
    t_tok                        w_tok [TABLE_ENTRIES+1];
    t_tok                        w_tail;
    t_wr                         w_wr;
    logic                        r_busy;
    logic                        r_pend_vld;
    logic                        r_pend_match;
    t_status                     r_pend_status;
    logic                        n_pend_match;
    t_status                     n_pend_status;
    logic                        r_out_vld;
    logic                        r_out_match;
    t_status                     r_out_status;
    logic                        w_acc;
    logic                        w_move;
    logic [LEN_W-1:0]            w_len;

    // configuration
    assign pready   = 1'b1;
    assign w_reg    = paddr[4:2];
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acl_cnt <= '0;
            r_acl_as  <= '0;
        end else if (w_cfg_wr) begin
            if (w_reg == REG_ACL_COUNT) r_acl_cnt <= pwdata[ACL_CNT_W-1:0];
            for (int j = 0; j < ACL_SLOTS; j++) begin
                if (w_reg == REG_ACL_AS_0 + REG_W'(j)) r_acl_as[j] <= pwdata;
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg == REG_ACL_COUNT) prdata = {{(32-ACL_CNT_W){1'b0}}, r_acl_cnt};
        for (int j = 0; j < ACL_SLOTS; j++) begin
            if (w_reg == REG_ACL_AS_0 + REG_W'(j)) prdata = r_acl_as[j];
        end
    end

    assign w_acl.used   = (r_acl_cnt > ACL_CNT_W'(ACL_SLOTS)) ? ACL_CNT_W'(ACL_SLOTS) : r_acl_cnt;
    assign w_acl.as_num = r_acl_as;

    // intake
    assign i_req.ready = !r_busy;
    assign w_acc       = i_req.valid && !r_busy;
    assign w_len       = (i_req.prefix_len > MAX_LEN) ? MAX_LEN : i_req.prefix_len;

    always_comb begin
        n_head            = '0;
        n_head.vld        = w_acc;
        n_head.req        = i_req.req_type;
        n_head.len        = w_len;
        n_head.asn        = i_req.origin_as;
        n_head.addr       = (i_req.req_type == REQ_ADD) ?
                            (i_req.address & len_mask(w_len)) : i_req.address;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_head <= '0;
        else          r_head <= n_head;
    end

    // cell row
    assign w_tok[0] = r_head;
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ptam_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_tok   (w_tok[g]),
            .i_wr    (w_wr),
            .i_acl   (w_acl),
            .o_tok   (w_tok[g+1])
        );
    end
    assign w_tail = w_tok[TABLE_ENTRIES];

    // end of row: place a new prefix and form the result
    always_comb begin
        w_wr.en  = w_tail.vld && w_tail.req == REQ_ADD && !w_tail.done && w_tail.free_found;
        w_wr.idx = w_tail.free_idx;
        w_wr.pfx = w_tail.addr;
        w_wr.len = w_tail.len;
        w_wr.asn = w_tail.asn;
        n_pend_match = 1'b0;
        if (w_tail.req == REQ_ADD) begin
            if (w_tail.done)            n_pend_status = w_tail.status;
            else if (w_tail.free_found) n_pend_status = ST_NEW;
            else                        n_pend_status = ST_TBL_FULL;
        end else if (w_tail.addr == 32'd0 || w_tail.addr == 32'hffff_ffff) begin
            n_pend_status = ST_REJECT;
        end else begin
            n_pend_status = ST_LOOKUP;
            n_pend_match  = w_tail.found && w_tail.hit;
        end
    end

    assign w_move = r_pend_vld && (!r_out_vld || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_acc)       r_busy <= 1'b1;
            else if (w_move) r_busy <= 1'b0;
            if (w_tail.vld)  r_pend_vld <= 1'b1;
            else if (w_move) r_pend_vld <= 1'b0;
            if (w_move)           r_out_vld <= 1'b1;
            else if (o_rsp.ready) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail.vld) begin
            r_pend_match  <= n_pend_match;
            r_pend_status <= n_pend_status;
        end
        if (w_move) begin
            r_out_match  <= r_pend_match;
            r_out_status <= r_pend_status;
        end
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.matched = r_out_match;
    assign o_rsp.status  = r_out_status;

    `PTAM_ASSERT_NXT(a_accept_busy, i_req.valid && i_req.ready, r_busy)
    `PTAM_ASSERT_IMP(a_tail_busy, w_tail.vld, r_busy && !r_pend_vld)
    `PTAM_ASSERT_IMP(a_pend_busy, r_pend_vld, r_busy && !r_head.vld)
endmodule

// File: dv/testbench.sv
// Self-checking testbench for the IPv4 prefix to AS number matcher
module testbench;
    import ptam_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ptam_req_if req_ch();
    ptam_rsp_if rsp_ch();

    prefix_to_as_number_matcher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    typedef struct packed {
        logic        req_type;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [31:0] origin_as;
    } t_lookup_req;

    typedef struct packed {
        logic    matched;
        t_status status;
    } t_lookup_rsp;

    // predictor copy of the route table and the access list
    logic                 tbl_valid [TABLE_ENTRIES];
    logic [31:0]          tbl_pfx   [TABLE_ENTRIES];
    logic [5:0]           tbl_len   [TABLE_ENTRIES];
    int                   tbl_cnt   [TABLE_ENTRIES];
    logic [31:0]          tbl_as    [TABLE_ENTRIES][AS_PER_PREFIX];
    logic [2:0]           acl_used;
    logic [31:0]          acl_as    [ACL_SLOTS];

    t_lookup_req pending_reqs[$];
    t_lookup_rsp expected_rsps[$];
    logic [31:0] known_pfx[$];

    int  mismatches = 0;
    int  rsp_seen   = 0;
    int  n_adds = 0, n_matches = 0, n_hits = 0;
    bit  hold_sender  = 0;
    bit  long_stall_req = 0;
    bit  timed_out = 0;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        return (len == 0) ? 32'h0 : (32'hffff_ffff << (32 - len));
    endfunction

    function automatic bit slot_lists(input int s, input logic [31:0] asn);
        for (int k = 0; k < tbl_cnt[s]; k++)
            if (tbl_as[s][k] == asn) return 1;
        return 0;
    endfunction

    function automatic t_lookup_rsp predict_lookup(input t_lookup_req r);
        t_lookup_rsp res;
        logic [5:0]  len;
        logic [31:0] pfx;
        int          free_slot;
        int          best;
        int          used;
        res = '0;
        if (r.req_type == REQ_ADD) begin
            len = (r.prefix_len > 32) ? 6'd32 : r.prefix_len;
            pfx = r.address & prefix_mask(len);
            free_slot = -1;
            for (int s = 0; s < TABLE_ENTRIES; s++) begin
                if (!tbl_valid[s]) begin
                    if (free_slot < 0) free_slot = s;
                    continue;
                end
                if (tbl_pfx[s] == pfx && tbl_len[s] == len) begin
                    if (slot_lists(s, r.origin_as)) res.status = ST_DUPLICATE;
                    else if (tbl_cnt[s] >= AS_PER_PREFIX) res.status = ST_LIST_FULL;
                    else begin
                        tbl_as[s][tbl_cnt[s]] = r.origin_as;
                        tbl_cnt[s]++;
                        res.status = ST_APPENDED;
                    end
                    return res;
                end
            end
            if (free_slot < 0) begin
                res.status = ST_TBL_FULL;
            end else begin
                tbl_valid[free_slot] = 1;
                tbl_pfx[free_slot]   = pfx;
                tbl_len[free_slot]   = len;
                tbl_cnt[free_slot]   = 1;
                tbl_as[free_slot][0] = r.origin_as;
                res.status = ST_NEW;
            end
            return res;
        end
        if (r.address == 32'h0 || r.address == 32'hffff_ffff) begin
            res.status = ST_REJECT;
            return res;
        end
        res.status = ST_LOOKUP;
        best = -1;
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
            if (!tbl_valid[s]) continue;
            if ((r.address & prefix_mask(tbl_len[s])) != tbl_pfx[s]) continue;
            if (best < 0 || tbl_len[s] > tbl_len[best]) best = s;
        end
        if (best < 0) return res;
        used = (acl_used > ACL_SLOTS) ? ACL_SLOTS : acl_used;
        for (int k = 0; k < used; k++)
            if (slot_lists(best, acl_as[k])) res.matched = 1;
        return res;
    endfunction

    // driver: offer the oldest pending item, idle at random
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 0;
        end else if (req_ch.valid && !req_ch.ready) begin
            // hold the item
        end else begin
            if (req_ch.valid && req_ch.ready) void'(pending_reqs.pop_front());
            if (gap_left > 0) begin
                gap_left--;
                req_ch.valid <= 0;
            end else if (pending_reqs.size() > 0 && !hold_sender) begin
                req_ch.valid      <= 1;
                req_ch.req_type   <= pending_reqs[0].req_type;
                req_ch.address    <= pending_reqs[0].address;
                req_ch.prefix_len <= pending_reqs[0].prefix_len;
                req_ch.origin_as  <= pending_reqs[0].origin_as;
                gap_left = ($urandom_range(0, 9) < 6) ? 0 :
                           ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                      : $urandom_range(20, 150);
            end else begin
                req_ch.valid <= 0;
            end
        end
    end

    // receiver backpressure; a requested long stall is counted here
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 0;
        end else if (long_stall_req) begin
            long_stall_req = 0;
            stall_left = 400;
            rsp_ch.ready <= 0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 0;
        end else if ($urandom_range(0, 9) < 7) begin
            rsp_ch.ready <= 1;
        end else begin
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                    : $urandom_range(30, 200);
            rsp_ch.ready <= 0;
        end
    end

    // predict on accept, check on result
    always @(posedge i_clk) begin
        t_lookup_req r;
        t_lookup_rsp e;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                r = {req_ch.req_type, req_ch.address, req_ch.prefix_len,
                     req_ch.origin_as};
                e = predict_lookup(r);
                if (r.req_type == REQ_ADD) n_adds++;
                else n_matches++;
                if (e.matched) n_hits++;
                expected_rsps.push_back(e);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_seen++;
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result with nothing expected: matched=%0b status=%0d",
                                 rsp_ch.matched, rsp_ch.status);
                end else begin
                    e = expected_rsps.pop_front();
                    if (rsp_ch.matched !== e.matched || rsp_ch.status !== e.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d exp matched=%0b status=%0d got matched=%0b status=%0d",
                                     rsp_seen, e.matched, e.status, rsp_ch.matched,
                                     rsp_ch.status);
                    end
                end
            end
        end
    end

    task automatic apb_write(input t_reg idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= 5'(idx) << 2; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_ACL_COUNT) acl_used = val[2:0];
        else if (idx - REG_ACL_AS_0 < ACL_SLOTS) acl_as[idx - REG_ACL_AS_0] = val;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic queue_item(input logic rt, input logic [31:0] a,
                              input logic [5:0] l, input logic [31:0] asn);
        pending_reqs.push_back({rt, a, l, asn});
        if (rt == REQ_ADD) known_pfx.push_back(a);
    endtask

    // pick an address near a known prefix so lookups hit the table
    function automatic logic [31:0] near_addr();
        if (known_pfx.size() == 0 || $urandom_range(0, 3) == 0) return $urandom();
        return known_pfx[$urandom_range(0, known_pfx.size() - 1)] ^
               (32'h1 << $urandom_range(0, 31)) ^ ($urandom_range(0, 1) ? $urandom() &
               32'hff : 32'h0);
    endfunction

    logic [31:0] as_pool[8];

    task automatic random_phase(input int n, input int max_len);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1))
                queue_item(REQ_ADD, near_addr(), 6'($urandom_range(0, max_len)),
                           as_pool[$urandom_range(0, 7)]);
            else
                queue_item(REQ_MATCH, near_addr(), 6'($urandom_range(0, 63)), $urandom());
        end
    endtask

    task automatic reset_table();
        foreach (tbl_valid[s]) tbl_valid[s] = 0;
    endtask

    initial begin
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        reset_table();
        acl_used = 0;
        foreach (acl_as[k]) acl_as[k] = 0;
        foreach (as_pool[k]) as_pool[k] = $urandom();
        as_pool[0] = 32'h0; as_pool[1] = 32'hffff_ffff;
        i_rst_n = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty table, rejects, extremes, duplicates, list full
        queue_item(REQ_MATCH, 32'h0a00_0001, '0, '0);
        queue_item(REQ_MATCH, 32'h0, '0, '0);
        queue_item(REQ_MATCH, 32'hffff_ffff, 6'h3f, 32'hffff_ffff);
        queue_item(REQ_ADD, 32'hffff_ffff, 6'd0, 32'h0);
        queue_item(REQ_MATCH, 32'h1234_5678, '0, '0);
        queue_item(REQ_ADD, 32'hc0a8_01ff, 6'd24, 32'd100);
        queue_item(REQ_ADD, 32'hc0a8_0100, 6'd24, 32'd100);
        queue_item(REQ_ADD, 32'hc0a8_0100, 6'd24, 32'd101);
        queue_item(REQ_ADD, 32'hc0a8_0100, 6'd24, 32'd102);
        queue_item(REQ_ADD, 32'hc0a8_0100, 6'd24, 32'hffff_ffff);
        queue_item(REQ_ADD, 32'hc0a8_0100, 6'd24, 32'd104);
        queue_item(REQ_ADD, 32'hc0a8_0105, 6'h3f, 32'd200);
        queue_item(REQ_ADD, 32'hc0a8_0105, 6'd32, 32'd201);
        queue_item(REQ_ADD, 32'hc000_0000, 6'd1, 32'd300);
        queue_item(REQ_MATCH, 32'hc0a8_0105, '0, '0);
        queue_item(REQ_MATCH, 32'hc0a8_0106, '0, '0);
        queue_item(REQ_MATCH, 32'h8000_0001, '0, '0);
        wait_drained();
        apb_write(REG_ACL_COUNT, 32'd7);
        apb_write(REG_ACL_AS_0, 32'd201);
        apb_write(t_reg'(REG_ACL_AS_0 + 1), 32'hffff_ffff);
        apb_write(t_reg'(REG_ACL_AS_0 + 2), 32'd300);
        apb_write(t_reg'(REG_ACL_AS_0 + 3), 32'd0);
        queue_item(REQ_MATCH, 32'hc0a8_0105, '0, '0);
        queue_item(REQ_MATCH, 32'hc0a8_0106, '0, '0);
        queue_item(REQ_MATCH, 32'h8000_0001, '0, '0);
        queue_item(REQ_MATCH, 32'h0000_0001, '0, '0);
        wait_drained();

        // random phases under several access list settings
        for (int ph = 0; ph < 6; ph++) begin
            apb_write(REG_ACL_COUNT, (ph == 0) ? 0 : (ph == 5) ? 7 : $urandom_range(1, 4));
            for (int k = 0; k < ACL_SLOTS; k++)
                apb_write(t_reg'(REG_ACL_AS_0 + k), as_pool[$urandom_range(0, 7)]);
            if (ph == 2) long_stall_req = 1;
            random_phase(140, (ph == 4) ? 63 : 32);
            if (ph == 3) begin
                // sender pauses until the block has drained
                while (pending_reqs.size() > 60) @(posedge i_clk);
                hold_sender = 1;
                while (req_ch.valid || expected_rsps.size() > 0) @(posedge i_clk);
                hold_sender = 0;
            end
            wait_drained();
        end

        $display("Covered %0d adds and %0d lookups (%0d access-list hits), %0d results",
                 n_adds, n_matches, n_hits, rsp_seen);
        $display("Six access-list settings, long receiver stall and sender drain pause");
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #12000000;
        $display("Timeout with %0d results outstanding", expected_rsps.size());
        $display("Regression FAIL");
        $finish;
    end
endmodule
